// ===== hdl/mht_pkg.sv =====
// ============================================================================
// Mail header tokenizer package
// Shared types, codes, limits and character classes for the header tokenizer.
// ============================================================================
package mht_pkg;

    localparam int MAX_HEADER_BYTES  = 65536;
    localparam int MAX_COMMENT_DEPTH = 255;
    localparam int MAX_RESULTS       = 3;

    localparam int POS_LIMIT_INT = ((MAX_HEADER_BYTES - 1) > 65535) ? 65535
                                                                     : (MAX_HEADER_BYTES - 1);
    localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);
    localparam logic [7:0]  DEPTH_MAX = 8'(MAX_COMMENT_DEPTH);

    localparam logic [2:0] PH_GROUND  = 3'd0;
    localparam logic [2:0] PH_ATOM    = 3'd1;
    localparam logic [2:0] PH_QUOTE   = 3'd2;
    localparam logic [2:0] PH_COMMENT = 3'd3;
    localparam logic [2:0] PH_CESC    = 3'd4;
    localparam logic [2:0] PH_LANGLE  = 3'd5;
    localparam logic [2:0] PH_BSLASH  = 3'd6;

    localparam logic [2:0] KIND_ATOM    = 3'd0;
    localparam logic [2:0] KIND_QUOTED  = 3'd1;
    localparam logic [2:0] KIND_COMMENT = 3'd2;
    localparam logic [2:0] KIND_SPECIAL = 3'd3;
    localparam logic [2:0] KIND_WARNING = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    localparam logic [2:0] WARN_NONE           = 3'd0;
    localparam logic [2:0] WARN_INVALID_GROUND = 3'd1;
    localparam logic [2:0] WARN_NESTED_ANGLE   = 3'd2;
    localparam logic [2:0] WARN_UNMATCHED      = 3'd3;
    localparam logic [2:0] WARN_UNEXPECTED_END = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LANGLE = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_RANGLE = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef struct packed {
        logic [2:0]  scan_phase;
        logic        inside_angle;
        logic [15:0] byte_position;
        logic [15:0] token_begin;
        logic [7:0]  comment_nesting;
        logic [15:0] tokens_seen;
    } mht_state_t;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [7:0]  special_char;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [2:0]  warning_code;
        logic [15:0] token_total;
    } mht_result_t;

    typedef mht_result_t [MAX_RESULTS-1:0] mht_result_vec_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_SPACE);
    endfunction

    function automatic logic is_atom_char(input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (b == CH_NUL || is_space(b))
        begin
            ok = 1'b0;
        end
        else
        begin
            case (b)
                CH_BANG, CH_DQUOTE, CH_PCT, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_DOT,
                CH_SLASH, CH_COLON, CH_SEMI, CH_LANGLE, CH_EQUAL, CH_RANGLE, CH_QMARK,
                CH_AT, CH_LBRACK, CH_RBRACK: ok = 1'b0;
                default: ok = 1'b1;
            endcase
        end
        return ok;
    endfunction

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] count_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic mht_result_t make_result(
        input logic [2:0]  kind,
        input logic [7:0]  sp,
        input logic [16:0] off,
        input logic [16:0] len,
        input logic [2:0]  wc,
        input logic [15:0] total
    );
        mht_result_t r;
        r.item_kind    = kind;
        r.special_char = sp;
        r.start_offset = sat16(off);
        r.token_length = sat16(len);
        r.warning_code = wc;
        r.token_total  = total;
        return r;
    endfunction

endpackage

// ===== hdl/mht_if.sv =====
// ============================================================================
// Mail header tokenizer channels
// Valid/ready channel interfaces for header bytes and for result items.
// ============================================================================
interface mht_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface mht_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  item_kind;
    logic [7:0]  special_char;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [2:0]  warning_code;
    logic [15:0] token_total;
    logic        last;

    modport source (output valid, output item_kind, output special_char,
                    output start_offset, output token_length, output warning_code,
                    output token_total, output last, input ready);
    modport sink (input valid, input item_kind, input special_char,
                  input start_offset, input token_length, input warning_code,
                  input token_total, input last, output ready);
endinterface

// ===== hdl/mail_header_tokenizer.sv =====
// ============================================================================
// Mail header tokenizer
// The first result of a byte is offered in the cycle after it is accepted.
// Throughput: one byte per cycle while the output is ready and each byte yields
// at most one result; a byte with more results holds the single output register.
// Reset: asynchronous, active low; scan state clears and warnings are enabled.
// ============================================================================
module mail_header_tokenizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    mht_byte_if.sink          byte_in,
    mht_item_if.source        item_out
);
    import mht_pkg::*;

    mht_state_t      state_reg;
    mht_state_t      state_next;
    logic            warn_enable_reg;
    mht_result_vec_t res_reg;
    mht_result_vec_t res_next;
    logic [1:0]      res_count;
    logic [1:0]      rem_reg;
    logic [1:0]      idx_reg;
    logic            accept;
    logic            pop;
    mht_result_t     cur;

    mht_step u_step (
        .state        (state_reg),
        .data_byte    (byte_in.data_byte),
        .warn_enable  (warn_enable_reg),
        .state_next   (state_next),
        .results      (res_next),
        .result_count (res_count)
    );

    assign pop           = item_out.valid && item_out.ready;
    assign byte_in.ready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && item_out.ready);
    assign accept        = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            warn_enable_reg <= 1'b1;
            rem_reg         <= 2'd0;
            idx_reg         <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                warn_enable_reg <= cfg_wdata;
            end
            if (accept)
            begin
                state_reg <= state_next;
                rem_reg   <= res_count;
                idx_reg   <= 2'd0;
            end
            else if (pop)
            begin
                rem_reg <= rem_reg - 2'd1;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign cur = res_reg[idx_reg];

    assign item_out.valid        = (rem_reg != 2'd0);
    assign item_out.item_kind    = cur.item_kind;
    assign item_out.special_char = cur.special_char;
    assign item_out.start_offset = cur.start_offset;
    assign item_out.token_length = cur.token_length;
    assign item_out.warning_code = cur.warning_code;
    assign item_out.token_total  = cur.token_total;
    assign item_out.last         = (rem_reg == 2'd1);

    // The pending results and those already sent never exceed one byte's worth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, idx_reg} + {1'b0, rem_reg}) <= 3'd3))
        else $error("result register over-run");

    // The byte position only moves when a transaction is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg.byte_position))
        else $error("byte position changed without a transaction");

    // A zero byte always ends the header and clears the scan state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (byte_in.data_byte == CH_NUL)) |=>
            (item_out.valid && (state_reg.byte_position == 16'd0) &&
             (state_reg.tokens_seen == 16'd0) && (state_reg.scan_phase == PH_GROUND)))
        else $error("header end not handled");

endmodule

// ===== hdl/mht_step.sv =====
// ============================================================================
// Mail header tokenizer step logic
// Computes the next scan state and the ordered results caused by one byte.
// ============================================================================
module mht_step (
    input  mht_pkg::mht_state_t      state,
    input  logic [7:0]               data_byte,
    input  logic                     warn_enable,
    output mht_pkg::mht_state_t      state_next,
    output mht_pkg::mht_result_vec_t results,
    output logic [1:0]               result_count
);
    import mht_pkg::*;

    mht_state_t      nx;
    mht_result_vec_t r;
    logic [1:0]      n;
    logic [15:0]     ts;
    logic [15:0]     pos;
    logic [15:0]     tb;
    logic [16:0]     tb_plus1;
    logic [16:0]     quote_len;
    logic [16:0]     atom_len;
    logic [16:0]     comment_len;
    logic            do_ground;
    logic            do_unterm;
    logic            ended;
    logic            atom_b;

    always_comb
    begin
        nx          = state;
        r           = '0;
        n           = 2'd0;
        ts          = state.tokens_seen;
        pos         = state.byte_position;
        tb          = state.token_begin;
        tb_plus1    = {1'b0, tb} + 17'd1;
        quote_len   = (pos > tb) ? {1'b0, pos - tb - 16'd1} : 17'd0;
        atom_len    = (pos > tb) ? {1'b0, pos - tb} : 17'd0;
        comment_len = ({1'b0, pos} + 17'd1) - {1'b0, tb};
        do_ground   = 1'b0;
        do_unterm   = 1'b0;
        ended       = 1'b0;
        atom_b      = is_atom_char(data_byte);

        case (state.scan_phase)
            PH_ATOM:
            begin
                if (!atom_b)
                begin
                    ts   = count_inc(ts);
                    r[n] = make_result(KIND_ATOM, 8'd0, {1'b0, tb}, atom_len, WARN_NONE, ts);
                    n    = n + 2'd1;
                    do_ground = 1'b1;
                end
            end
            PH_QUOTE:
            begin
                if (data_byte == CH_DQUOTE)
                begin
                    ts   = count_inc(ts);
                    r[n] = make_result(KIND_QUOTED, 8'd0, tb_plus1, quote_len, WARN_NONE, ts);
                    n    = n + 2'd1;
                    nx.scan_phase = PH_GROUND;
                end
                else if (data_byte == CH_NUL)
                begin
                    do_unterm = 1'b1;
                end
            end
            PH_COMMENT:
            begin
                if (data_byte == CH_NUL)
                begin
                    do_unterm = 1'b1;
                end
                else if (data_byte == CH_LPAREN)
                begin
                    if (state.comment_nesting < DEPTH_MAX)
                    begin
                        nx.comment_nesting = state.comment_nesting + 8'd1;
                    end
                end
                else if (data_byte == CH_RPAREN)
                begin
                    if (state.comment_nesting != 8'd0)
                    begin
                        nx.comment_nesting = state.comment_nesting - 8'd1;
                    end
                    if (nx.comment_nesting == 8'd0)
                    begin
                        ts   = count_inc(ts);
                        r[n] = make_result(KIND_COMMENT, 8'd0, {1'b0, tb}, comment_len,
                                           WARN_NONE, ts);
                        n    = n + 2'd1;
                        nx.scan_phase = PH_GROUND;
                    end
                end
                else if (data_byte == CH_BSLASH)
                begin
                    nx.scan_phase = PH_CESC;
                end
            end
            PH_CESC:
            begin
                if (data_byte == CH_NUL)
                begin
                    do_unterm = 1'b1;
                end
                else
                begin
                    nx.scan_phase = PH_COMMENT;
                end
            end
            PH_LANGLE:
            begin
                if (data_byte == CH_RANGLE)
                begin
                    ts   = count_inc(ts);
                    r[n] = make_result(KIND_SPECIAL, CH_LANGLE, {1'b0, tb}, 17'd1,
                                       WARN_NONE, ts);
                    n    = n + 2'd1;
                    ts   = count_inc(ts);
                    r[n] = make_result(KIND_ATOM, 8'd0, {1'b0, pos}, 17'd0, WARN_NONE, ts);
                    n    = n + 2'd1;
                    ts   = count_inc(ts);
                    r[n] = make_result(KIND_SPECIAL, CH_RANGLE, {1'b0, pos}, 17'd1,
                                       WARN_NONE, ts);
                    n    = n + 2'd1;
                    nx.scan_phase = PH_GROUND;
                end
                else
                begin
                    if (state.inside_angle)
                    begin
                        if (warn_enable)
                        begin
                            r[n] = make_result(KIND_WARNING, 8'd0, {1'b0, tb}, 17'd0,
                                               WARN_NESTED_ANGLE, ts);
                            n    = n + 2'd1;
                        end
                    end
                    else
                    begin
                        nx.inside_angle = 1'b1;
                        ts   = count_inc(ts);
                        r[n] = make_result(KIND_SPECIAL, CH_LANGLE, {1'b0, tb}, 17'd1,
                                           WARN_NONE, ts);
                        n    = n + 2'd1;
                    end
                    do_ground = 1'b1;
                end
            end
            PH_BSLASH:
            begin
                if (atom_b)
                begin
                    nx.scan_phase = PH_ATOM;
                end
                else
                begin
                    if (warn_enable)
                    begin
                        r[n] = make_result(KIND_WARNING, 8'd0, {1'b0, tb}, 17'd0,
                                           WARN_INVALID_GROUND, ts);
                        n    = n + 2'd1;
                    end
                    do_ground = 1'b1;
                end
            end
            default:
            begin
                do_ground = 1'b1;
            end
        endcase

        if (do_ground)
        begin
            nx.scan_phase = PH_GROUND;
            if (data_byte == CH_NUL)
            begin
                r[n]  = make_result(KIND_END, 8'd0, {1'b0, pos}, 17'd0, WARN_NONE, ts);
                n     = n + 2'd1;
                ended = 1'b1;
            end
            else if (!is_space(data_byte))
            begin
                case (data_byte)
                    CH_DQUOTE:
                    begin
                        nx.scan_phase  = PH_QUOTE;
                        nx.token_begin = pos;
                    end
                    CH_LPAREN:
                    begin
                        nx.scan_phase      = PH_COMMENT;
                        nx.token_begin     = pos;
                        nx.comment_nesting = 8'd1;
                    end
                    CH_RPAREN:
                    begin
                        if (warn_enable)
                        begin
                            r[n] = make_result(KIND_WARNING, 8'd0, {1'b0, pos}, 17'd0,
                                               WARN_INVALID_GROUND, ts);
                            n    = n + 2'd1;
                        end
                    end
                    CH_LANGLE:
                    begin
                        nx.scan_phase  = PH_LANGLE;
                        nx.token_begin = pos;
                    end
                    CH_RANGLE:
                    begin
                        if (!nx.inside_angle)
                        begin
                            if (warn_enable)
                            begin
                                r[n] = make_result(KIND_WARNING, 8'd0, {1'b0, pos}, 17'd0,
                                                   WARN_UNMATCHED, ts);
                                n    = n + 2'd1;
                            end
                        end
                        else
                        begin
                            nx.inside_angle = 1'b0;
                            ts   = count_inc(ts);
                            r[n] = make_result(KIND_SPECIAL, CH_RANGLE, {1'b0, pos}, 17'd1,
                                               WARN_NONE, ts);
                            n    = n + 2'd1;
                        end
                    end
                    CH_BSLASH:
                    begin
                        nx.scan_phase  = PH_BSLASH;
                        nx.token_begin = pos;
                    end
                    default:
                    begin
                        if (atom_b)
                        begin
                            nx.scan_phase  = PH_ATOM;
                            nx.token_begin = pos;
                        end
                        else
                        begin
                            ts   = count_inc(ts);
                            r[n] = make_result(KIND_SPECIAL, data_byte, {1'b0, pos}, 17'd1,
                                               WARN_NONE, ts);
                            n    = n + 2'd1;
                        end
                    end
                endcase
            end
        end

        if (do_unterm)
        begin
            if (warn_enable)
            begin
                r[n] = make_result(KIND_WARNING, 8'd0, {1'b0, pos}, 17'd0,
                                   WARN_UNEXPECTED_END, ts);
                n    = n + 2'd1;
            end
            ts   = count_inc(ts);
            r[n] = make_result(KIND_QUOTED, 8'd0, tb_plus1, quote_len, WARN_NONE, ts);
            n    = n + 2'd1;
            r[n] = make_result(KIND_END, 8'd0, {1'b0, pos}, 17'd0, WARN_NONE, ts);
            n    = n + 2'd1;
            ended = 1'b1;
        end

        if (ended)
        begin
            nx = '0;
        end
        else
        begin
            nx.tokens_seen = ts;
            if (pos < POS_LIMIT)
            begin
                nx.byte_position = pos + 16'd1;
            end
        end
    end

    assign state_next   = nx;
    assign results      = r;
    assign result_count = n;

endmodule
